FILE: hdl/selection_sort_descending_top_macros.svh
// Assertion macros for the descending sorter
`ifndef SELECTION_SORT_DESCENDING_TOP_MACROS_SVH
`define SELECTION_SORT_DESCENDING_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset
`define SSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/ssd_pkg.sv
// Shared types and constants for the descending sorter
package ssd_pkg;

  localparam int unsigned ElemW = 8;

  typedef logic signed [ElemW-1:0] elem_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic shift;
  } ssd_ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } ssd_state_e;

endpackage

FILE: hdl/ssd_cell.sv
// One cell of the sorting chain: holds a single element and its valid flag
module ssd_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssd_pkg::ssd_ctrl_t ctrl_i,
  input  ssd_pkg::elem_t    new_val_i,
  input  logic              left_gt_i,
  input  ssd_pkg::elem_t    left_val_i,
  input  logic              left_valid_i,
  input  ssd_pkg::elem_t    right_val_i,
  input  logic              right_valid_i,
  output logic              gt_o,
  output ssd_pkg::elem_t    val_o,
  output logic              valid_o
);
  import ssd_pkg::*;

  elem_t val_q, val_d;
  logic  valid_q, valid_d;

  // Empty slot or strictly smaller element: the new one belongs here or earlier
  assign gt_o = !valid_q || (new_val_i > val_q);

  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    priority if (ctrl_i.shift) begin
      val_d   = right_val_i;
      valid_d = right_valid_i;
    end else if (ctrl_i.insert) begin
      priority if (left_gt_i) begin
        val_d   = left_val_i;
        valid_d = left_valid_i;
      end else if (gt_o) begin
        val_d   = new_val_i;
        valid_d = 1'b1;
      end else begin
        // new item lands further right, this element stays
        val_d   = val_q;
        valid_d = valid_q;
      end
    end else begin
      val_d   = val_q;
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o   = val_q;
  assign valid_o = valid_q;

endmodule

FILE: hdl/selection_sort_descending_top.sv
// Descending sorter: the first result is offered in the cycle after the last
// item is taken. Input takes one item per cycle while loading; a set of N kept
// items is then emitted at one item per cycle while out_ready_i is high; no input is taken meanwhile.
// The rate is set by the chain of DEPTH cells, one insert or one shift per cycle.
// Reset (rst_ni low, asynchronous) empties every cell and clears the item count;
// cell contents themselves are not reset.
module selection_sort_descending_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [7:0]    value_i,
  input  logic                 last_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [7:0]    value_res_o,
  output logic                 last_res_o
);
  import ssd_pkg::*;

`include "selection_sort_descending_top_macros.svh"

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // Sequencer: load items into the chain, then drain it from cell 0
  ssd_state_e          state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  ssd_ctrl_t           ctrl;

  logic                in_acc;
  logic                out_acc;
  logic                room;

  // Chain wiring
  elem_t               cell_val [DEPTH];
  logic [DEPTH-1:0]    cell_valid;
  logic [DEPTH-1:0]    cell_gt;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  // Items beyond DEPTH are dropped, but their last flag still ends the set
  assign room    = count_q < CntW'(DEPTH);

  // Next state
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (last_i) begin
            state_d = ST_EMIT;
            count_d = '0;
          end else if (room) begin
            count_d = count_q + CntW'(1);
          end
        end
      end
      ST_EMIT: begin
        // Final item leaves when cell 1 is empty
        if (out_acc && !cell_valid[1]) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Outputs and cell commands
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    ctrl        = '0;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o  = 1'b1;
        ctrl.insert = in_acc && room;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        ctrl.shift  = out_acc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Chain of cells, kept in descending order from cell 0. Each new item is
  // inserted after all elements that are greater or equal; the smaller ones
  // step one cell to the right in the same cycle.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    elem_t left_val, right_val;
    logic  left_gt, left_valid, right_valid;

    if (i == 0) begin : g_head
      assign left_gt    = 1'b0;
      assign left_val   = value_i;
      assign left_valid = 1'b0;
    end else begin : g_body
      assign left_gt    = cell_gt[i-1];
      assign left_val   = cell_val[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_val   = value_i;
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_val   = cell_val[i+1];
      assign right_valid = cell_valid[i+1];
    end

    ssd_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_val_i     (value_i),
      .left_gt_i     (left_gt),
      .left_val_i    (left_val),
      .left_valid_i  (left_valid),
      .right_val_i   (right_val),
      .right_valid_i (right_valid),
      .gt_o          (cell_gt[i]),
      .val_o         (cell_val[i]),
      .valid_o       (cell_valid[i])
    );
  end

  // Head of the chain is the result register
  assign value_res_o = cell_val[0];
  assign last_res_o  = !cell_valid[1];

  // While loading, the count tracks the occupied cells
  `SSD_ASSERT_NOW(a_count_matches, state_q == ST_LOAD, $countones(cell_valid) == count_q, "item count differs from occupied cells")
  // A result on offer always comes from an occupied head cell
  `SSD_ASSERT_NOW(a_head_valid, out_valid_o, cell_valid[0], "result offered from empty head cell")
  // Final result taken leaves the chain empty and ready for a new set
  `SSD_ASSERT_NEXT(a_drain_done, out_acc && last_res_o, in_ready_o && (cell_valid == '0), "chain not empty after final result")
  // A closing item starts the drain at once
  `SSD_ASSERT_NEXT(a_emit_start, in_acc && last_i, out_valid_o && !in_ready_o, "no result after closing item")

endmodule

FILE: sim/selection_sort_descending_top_test.sv
// Self-checking testbench for the descending selection sorter
`timescale 1ns / 1ps

module selection_sort_descending_top_test;
  import ssd_pkg::*;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned RAND_ITEMS = 350;
  localparam int unsigned MAX_ERRS   = 10;
  localparam int unsigned TAIL_WAIT  = 40;     // idle tail after the last expected result
  localparam int unsigned HOLD_LEN   = 160;    // long receiver hold-off, in cycles
  localparam longint     CYCLE_CAP   = 300000;

  // One element offered to the sorter; drain holds it back until all results are in
  typedef struct {
    elem_t value;
    logic  last;
    logic  drain;
  } feed_item_t;

  // One sorted element expected back
  typedef struct {
    elem_t value;
    logic  last;
  } sorted_item_t;

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  in_valid_i  = 1'b0;
  logic  in_ready_o;
  elem_t value_i     = '0;
  logic  last_i      = 1'b0;
  logic  out_valid_o;
  logic  out_ready_i = 1'b0;
  elem_t value_res_o;
  logic  last_res_o;

  feed_item_t   feed_q[$];
  sorted_item_t sorted_q[$];
  elem_t        set_buf[$];   // elements kept so far in the current set

  int unsigned total_items = 0;
  int unsigned in_count    = 0;
  int unsigned err_cnt     = 0;
  int unsigned hold_left   = 0;
  int unsigned hold_at     = 0;
  logic        hold_done   = 1'b0;
  logic        in_fire     = 1'b0;
  longint      cycle_cnt   = 0;

  selection_sort_descending_top #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .value_res_o(value_res_o),
    .last_res_o (last_res_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor: keep up to DEPTH elements of a set, drop the rest, and on the
  // last flag sort the kept ones into descending order. Equal values are
  // indistinguishable on the output, so the tie order does not matter.
  // ---------------------------------------------------------------------------
  task automatic take_element(input elem_t v, input logic fin);
    int           i;
    int           j;
    int           best;
    elem_t        top;
    sorted_item_t res;
    if (set_buf.size() < DEPTH) set_buf.push_back(v);
    if (fin) begin
      for (i = 0; i + 1 < set_buf.size(); i++) begin
        top  = set_buf[i];
        best = i;
        for (j = i + 1; j < set_buf.size(); j++) begin
          if (set_buf[j] > top) begin
            top  = set_buf[j];
            best = j;
          end
        end
        set_buf[best] = set_buf[i];
        set_buf[i]    = top;
      end
      for (i = 0; i < set_buf.size(); i++) begin
        res.value = set_buf[i];
        res.last  = (i == set_buf.size() - 1);
        sorted_q.push_back(res);
      end
      set_buf.delete();
    end
  endtask

  task automatic push_elem(input elem_t v, input logic fin, input logic drain);
    feed_item_t it;
    it.value = v;
    it.last  = fin;
    it.drain = drain;
    feed_q.push_back(it);
  endtask

  // Random set: mostly 1..DEPTH long, now and then overlong so the tail is dropped
  task automatic add_random_set(input logic drain);
    int    n;
    int    k;
    int    mode;
    elem_t v;
    n    = ($urandom_range(99) < 12) ? $urandom_range(DEPTH + 6, DEPTH + 1)
                                     : $urandom_range(DEPTH, 1);
    mode = $urandom_range(3);
    for (k = 0; k < n; k++) begin
      case (mode)
        0:       v = elem_t'($urandom_range(6)) - elem_t'(3);      // many duplicates
        1:       v = ($urandom_range(1) != 0) ? elem_t'(8'sh7f) : elem_t'(8'sh80);
        default: v = elem_t'($urandom);
      endcase
      push_elem(v, k == n - 1, drain && (k == 0));
    end
  endtask

  // Idle percentages by phase: sender 27/61/0, receiver 61/27/0
  function automatic int unsigned idle_pct(input logic sender);
    if (in_count < total_items / 3)       return sender ? 27 : 61;
    if (in_count < (2 * total_items) / 3) return sender ? 61 : 27;
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int s;
    // Single-element set
    push_elem(8'sh7f, 1'b1, 1'b0);
    // Overlong set: 16 kept with both extremes and alternating bit patterns,
    // then a dropped last element that would otherwise have sorted first
    push_elem(8'sh80, 1'b0, 1'b0);
    push_elem(8'sh7f, 1'b0, 1'b0);
    push_elem(8'sh00, 1'b0, 1'b0);
    push_elem(8'sh55, 1'b0, 1'b0);
    push_elem(-8'sh56, 1'b0, 1'b0);
    push_elem(-8'sh01, 1'b0, 1'b0);
    push_elem(8'sh01, 1'b0, 1'b0);
    push_elem(8'sh7e, 1'b0, 1'b0);
    push_elem(-8'sh7f, 1'b0, 1'b0);
    push_elem(8'sh10, 1'b0, 1'b0);
    push_elem(8'sh10, 1'b0, 1'b0);
    push_elem(-8'sh20, 1'b0, 1'b0);
    push_elem(8'sh40, 1'b0, 1'b0);
    push_elem(8'sh02, 1'b0, 1'b0);
    push_elem(-8'sh02, 1'b0, 1'b0);
    push_elem(8'sh33, 1'b0, 1'b0);
    push_elem(8'sh7f, 1'b1, 1'b0);
    // Equal values mixed with a smaller one
    push_elem(8'sh05, 1'b0, 1'b1);
    push_elem(8'sh05, 1'b0, 1'b0);
    push_elem(-8'sh03, 1'b0, 1'b0);
    push_elem(8'sh05, 1'b1, 1'b0);
    // Already ascending, worst case for the swaps
    push_elem(-8'sh32, 1'b0, 1'b0);
    push_elem(8'sh00, 1'b0, 1'b0);
    push_elem(8'sh64, 1'b1, 1'b0);

    s = 0;
    while (feed_q.size() < RAND_ITEMS) begin
      // every tenth set waits for the sorter to drain completely
      add_random_set((s % 10) == 5);
      s++;
    end
    total_items = feed_q.size();
    hold_at     = (3 * total_items) / 4;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (in_count == total_items);
    wait (sorted_q.size() == 0);
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("selection_sort_descending_top_test OK");
    end else begin
      $display("selection_sort_descending_top_test NOT OK");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: changes inputs on the falling edge. An item stays offered until
  // the rising edge that takes it (in_fire), then the next one may follow.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_items
    feed_item_t nxt;
    logic       go;
    if (rst_ni && !(in_valid_i && !in_fire)) begin
      go = 1'b0;
      if (feed_q.size() != 0) begin
        if (!(feed_q[0].drain && sorted_q.size() != 0)) begin
          go = ($urandom_range(99) >= idle_pct(1'b1));
        end
      end
      if (go) begin
        nxt = feed_q.pop_front();
        value_i <= nxt.value;
        last_i  <= nxt.last;
      end else begin
        // junk on the payload while nothing is offered
        value_i <= elem_t'($urandom);
        last_i  <= 1'($urandom_range(1));
      end
      in_valid_i <= go;
    end
  end

  // Receiver: random stalls, plus one long hold-off late in the run so the
  // sorter fills up and has to refuse input
  always @(negedge clk_i) begin : drive_ready
    if (rst_ni) begin
      if (!hold_done && in_count >= hold_at) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= idle_pct(1'b0));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples both handshakes on the rising edge, feeds the predictor
  // and checks each result against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_ports
    sorted_item_t want;
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        take_element(value_i, last_i);
        in_count++;
      end
      if (out_valid_o && out_ready_i) begin
        if (sorted_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_ERRS) begin
            $display("%0t: unexpected result value=%0d last=%0b",
                     $realtime, value_res_o, last_res_o);
          end
        end else begin
          want = sorted_q.pop_front();
          if (value_res_o !== want.value || last_res_o !== want.last) begin
            err_cnt++;
            if (err_cnt <= MAX_ERRS) begin
              $display("%0t: mismatch value exp=%0d got=%0d, last exp=%0b got=%0b",
                       $realtime, want.value, value_res_o, want.last, last_res_o);
            end
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("selection_sort_descending_top_test NOT OK");
      $finish;
    end
  end

endmodule
